[hw/rtl/qsa_pkg.sv]
// Shared types, widths and the arctangent table for the quaternion angle pipeline.
package qsa_pkg;

   localparam int CW       = 38;   // CORDIC x/y width
   localparam int ZW       = 32;   // angle width, 2^32 per turn
   localparam int SQ_W     = 62;   // square-root remainder and root width
   localparam int SQ_STEPS = 31;   // one cell per result bit of the root
   localparam int SQ_TOP   = 60;   // bit position of the first trial bit
   localparam int DLY      = SQ_STEPS + 1;
   localparam int OUT_W    = 48;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [ZW-1:0]        z;
      logic                 tag;
   } cordic_word_type;

   typedef struct packed {
      logic [SQ_W-1:0]  rem;
      logic [SQ_W-1:0]  root;
      logic signed [31:0] sin;
   } isqrt_word_type;

   localparam logic [31:0] ATAN_TABLE [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   function automatic logic [31:0] atan_entry(input int n);
      logic [4:0] idx;
      idx = n[4:0];
      if (n > 31) begin
         return 32'd0;
      end
      return ATAN_TABLE[idx];
   endfunction

endpackage

[hw/rtl/qsa_isqrt_cell.sv]
// One restoring square-root cell: trial subtract of one root bit, registered.
module qsa_isqrt_cell #(
   parameter int BIT = 60
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    up_valid,
   input  qsa_pkg::isqrt_word_type up_data,
   output logic                    dn_valid,
   output qsa_pkg::isqrt_word_type dn_data
);

   localparam logic [qsa_pkg::SQ_W-1:0] B = qsa_pkg::SQ_W'(1) << BIT;

   logic                    valid_ff;
   qsa_pkg::isqrt_word_type data_ff, data_in;
   logic [qsa_pkg::SQ_W-1:0] trial;
   logic                    fits;

   always_comb begin
      trial = up_data.root + B;
      fits  = up_data.rem >= trial;
      data_in.sin  = up_data.sin;
      data_in.rem  = fits ? (up_data.rem - trial) : up_data.rem;
      data_in.root = (up_data.root >> 1) + (fits ? B : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[hw/rtl/qsa_cordic_cell.sv]
// One vectoring CORDIC cell: rotate toward the x axis by atan(2^-SHIFT), registered.
module qsa_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     up_valid,
   input  qsa_pkg::cordic_word_type up_data,
   output logic                     dn_valid,
   output qsa_pkg::cordic_word_type dn_data
);

   localparam logic [qsa_pkg::ZW-1:0] T = qsa_pkg::atan_entry(SHIFT);

   logic                     valid_ff;
   qsa_pkg::cordic_word_type data_ff, data_in;
   logic signed [qsa_pkg::CW-1:0] dx, dy;

   always_comb begin
      dx = up_data.y >>> SHIFT;
      dy = up_data.x >>> SHIFT;
      data_in.tag = up_data.tag;
      if (!up_data.y[qsa_pkg::CW-1]) begin
         data_in.x = up_data.x + dx;
         data_in.y = up_data.y - dy;
         data_in.z = up_data.z + T;
      end else begin
         data_in.x = up_data.x - dx;
         data_in.y = up_data.y + dy;
         data_in.z = up_data.z - T;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[hw/rtl/quaternion_to_spherical_angles.sv]
// Quaternion to right ascension, declination and roll: product stages, root and CORDIC cells.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: q_real, q_i, q_j, q_k
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: right_ascension, declination, roll_angle
//
// One request per cycle while no result is held; a request passes three front stages, the square,
// 31 root cells, then the CORDIC cells of the declination path.
// Reset clears all valid bits; no clearing pass.
// A held result stalls the whole row of cells; req_tready is low only then.
module quaternion_to_spherical_angles #(
   parameter int CORDIC_STEPS   = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // q_real, q_i, q_j, q_k, each COMPONENT_BITS, zero padded to bytes
   input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // right_ascension[15:0], declination[31:16], roll_angle[47:32]
   output logic [qsa_pkg::OUT_W-1:0] rsp_tdata
);

   localparam int CB = COMPONENT_BITS;
   localparam int CS = CORDIC_STEPS;
   localparam int DL = qsa_pkg::DLY;

   logic adv;
   logic rsp_tvalid_ff;
   logic [qsa_pkg::OUT_W-1:0] rsp_tdata_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // align components to Q1.15
   logic signed [15:0] comp [0:3];
   genvar gc;
   generate
      for (gc = 0; gc < 4; gc++) begin : g_comp
         if (CB >= 16) begin : g_wide
            assign comp[gc] = req_tdata[gc*CB + CB - 1 -: 16];
         end else begin : g_narrow
            assign comp[gc] = {req_tdata[gc*CB +: CB], {(16-CB){1'b0}}};
         end
      end
   endgenerate

   // stage 0: components
   logic s0_valid_ff;
   logic signed [15:0] r_ff, i_ff, j_ff, k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= comp[0];
         i_ff <= comp[1];
         j_ff <= comp[2];
         k_ff <= comp[3];
      end
   end

   // stage 1: products
   logic s1_valid_ff;
   logic signed [31:0] ij_ff, rk_ff, jj_ff, kk_ff, rj_ff, ik_ff, jk_ff, ri_ff, ii_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ij_ff <= i_ff * j_ff;
         rk_ff <= r_ff * k_ff;
         jj_ff <= j_ff * j_ff;
         kk_ff <= k_ff * k_ff;
         rj_ff <= r_ff * j_ff;
         ik_ff <= i_ff * k_ff;
         jk_ff <= j_ff * k_ff;
         ri_ff <= r_ff * i_ff;
         ii_ff <= i_ff * i_ff;
      end
   end

   // stage 2: atan2 operands and clamped arcsine argument
   localparam logic signed [33:0] ONE34 = 34'sd1 <<< 30;

   logic s2_valid_ff;
   logic signed [33:0] ray_ff, rax_ff, rly_ff, rlx_ff;
   logic signed [31:0] sin_ff;
   logic signed [33:0] sraw;
   logic signed [31:0] sin_in;

   always_comb begin
      sraw = -((34'(rj_ff) + 34'(ik_ff)) <<< 1);
      if (sraw > ONE34) begin
         sin_in = 32'sd1 <<< 30;
      end else if (sraw < -ONE34) begin
         sin_in = -(32'sd1 <<< 30);
      end else begin
         sin_in = 32'(sraw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ray_ff <= (34'(ij_ff) - 34'(rk_ff)) <<< 1;
         rax_ff <= ONE34 - ((34'(jj_ff) + 34'(kk_ff)) <<< 1);
         rly_ff <= (34'(jk_ff) - 34'(ri_ff)) <<< 1;
         rlx_ff <= ONE34 - ((34'(ii_ff) + 34'(jj_ff)) <<< 1);
         sin_ff <= sin_in;
      end
   end

   // atan2 quadrant fold into the first CORDIC cell
   function automatic qsa_pkg::cordic_word_type fold(input logic signed [33:0] y,
                                                     input logic signed [33:0] x);
      qsa_pkg::cordic_word_type w;
      logic signed [qsa_pkg::CW-1:0] xe, ye;
      xe = qsa_pkg::CW'(x);
      ye = qsa_pkg::CW'(y);
      w.tag = (x == 34'sd0) && (y == 34'sd0);
      if (x < 34'sd0) begin
         w.x = -xe;
         w.y = -ye;
         w.z = 32'h8000_0000;
      end else begin
         w.x = xe;
         w.y = ye;
         w.z = '0;
      end
      return w;
   endfunction

   logic                     ra_v [0:CS];
   qsa_pkg::cordic_word_type ra_c [0:CS];
   logic                     rl_v [0:CS];
   qsa_pkg::cordic_word_type rl_c [0:CS];
   logic                     dc_v [0:CS];
   qsa_pkg::cordic_word_type dc_c [0:CS];

   assign ra_v[0] = s2_valid_ff;
   assign ra_c[0] = fold(ray_ff, rax_ff);
   assign rl_v[0] = s2_valid_ff;
   assign rl_c[0] = fold(rly_ff, rlx_ff);

   // declination path: square, then root cells
   logic s3_valid_ff;
   logic [60:0] sq_ff;
   logic signed [31:0] sin3_ff;
   logic signed [63:0] sq_full;

   assign sq_full = sin_ff * sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= sq_full[60:0];
         sin3_ff <= sin_ff;
      end
   end

   logic                    sq_v [0:qsa_pkg::SQ_STEPS];
   qsa_pkg::isqrt_word_type sq_c [0:qsa_pkg::SQ_STEPS];

   assign sq_v[0]      = s3_valid_ff;
   assign sq_c[0].rem  = (qsa_pkg::SQ_W'(1) << 60) - qsa_pkg::SQ_W'(sq_ff);
   assign sq_c[0].root = '0;
   assign sq_c[0].sin  = sin3_ff;

   genvar gs;
   generate
      for (gs = 0; gs < qsa_pkg::SQ_STEPS; gs++) begin : g_sqrt
         qsa_isqrt_cell #(
            .BIT(qsa_pkg::SQ_TOP - 2*gs)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .enable  (adv),
            .up_valid(sq_v[gs]),
            .up_data (sq_c[gs]),
            .dn_valid(sq_v[gs+1]),
            .dn_data (sq_c[gs+1])
         );
      end
   endgenerate

   assign dc_v[0]     = sq_v[qsa_pkg::SQ_STEPS];
   assign dc_c[0].x   = qsa_pkg::CW'(sq_c[qsa_pkg::SQ_STEPS].root);
   assign dc_c[0].y   = qsa_pkg::CW'(sq_c[qsa_pkg::SQ_STEPS].sin);
   assign dc_c[0].z   = '0;
   assign dc_c[0].tag = 1'b0;

   genvar gk;
   generate
      for (gk = 0; gk < CS; gk++) begin : g_cordic
         qsa_cordic_cell #(.SHIFT(gk)) u_ra (
            .clock(clock), .reset(reset), .enable(adv),
            .up_valid(ra_v[gk]), .up_data(ra_c[gk]),
            .dn_valid(ra_v[gk+1]), .dn_data(ra_c[gk+1])
         );
         qsa_cordic_cell #(.SHIFT(gk)) u_rl (
            .clock(clock), .reset(reset), .enable(adv),
            .up_valid(rl_v[gk]), .up_data(rl_c[gk]),
            .dn_valid(rl_v[gk+1]), .dn_data(rl_c[gk+1])
         );
         qsa_cordic_cell #(.SHIFT(gk)) u_dc (
            .clock(clock), .reset(reset), .enable(adv),
            .up_valid(dc_v[gk]), .up_data(dc_c[gk]),
            .dn_valid(dc_v[gk+1]), .dn_data(dc_c[gk+1])
         );
      end
   endgenerate

   // round right ascension and roll, then hold them until declination catches up
   logic [31:0] ra_a, rl_a, rl_n;
   logic [15:0] ra_16, rl_16;

   always_comb begin
      ra_a  = ra_c[CS].tag ? 32'd0 : ra_c[CS].z;
      rl_a  = rl_c[CS].tag ? 32'd0 : rl_c[CS].z;
      rl_n  = 32'd0 - rl_a;
      ra_16 = ra_a[31:16] + 16'(ra_a[15]);
      rl_16 = rl_n[31:16] + 16'(rl_n[15]);
   end

   logic        dly_valid_ff [0:DL-1];
   logic [15:0] dly_ra_ff    [0:DL-1];
   logic [15:0] dly_rl_ff    [0:DL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < DL; n++) begin
            dly_valid_ff[n] <= 1'b0;
         end
      end else if (adv) begin
         dly_valid_ff[0] <= ra_v[CS];
         for (int n = 1; n < DL; n++) begin
            dly_valid_ff[n] <= dly_valid_ff[n-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ra_ff[0] <= ra_16;
         dly_rl_ff[0] <= rl_16;
         for (int n = 1; n < DL; n++) begin
            dly_ra_ff[n] <= dly_ra_ff[n-1];
            dly_rl_ff[n] <= dly_rl_ff[n-1];
         end
      end
   end

   // declination: negate, round, saturate
   logic signed [32:0] dneg, drnd;
   logic signed [16:0] dsh;
   logic signed [15:0] dec_16;

   always_comb begin
      dneg = -33'(signed'(dc_c[CS].z));
      drnd = dneg + 33'sd32768;
      dsh  = 17'(drnd >>> 16);
      if (dsh > 17'sd16384) begin
         dec_16 = 16'sd16384;
      end else if (dsh < -17'sd16384) begin
         dec_16 = -16'sd16384;
      end else begin
         dec_16 = 16'(dsh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= dc_v[CS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {dly_rl_ff[DL-1], dec_16, dly_ra_ff[DL-1]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      dly_valid_ff[DL-1] == dc_v[CS])
      else $error("angle paths out of step");

   assert property (@(posedge clock) disable iff (reset)
      ra_v[CS] == rl_v[CS])
      else $error("right ascension and roll paths out of step");

   assert property (@(posedge clock) disable iff (reset)
      sq_v[qsa_pkg::SQ_STEPS] |-> (sq_c[qsa_pkg::SQ_STEPS].root <= (qsa_pkg::SQ_W'(1) << 30)))
      else $error("root beyond one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((signed'(rsp_tdata[31:16]) <= 16'sd16384)
                   && (signed'(rsp_tdata[31:16]) >= -16'sd16384)))
      else $error("declination out of range");
`endif

endmodule

[test/quaternion_to_spherical_angles_tb.sv]
// Self-checking testbench: quaternions in, predicted right ascension, declination and roll out.
module quaternion_to_spherical_angles_tb;

   localparam int STEPS = 16;
   localparam int LATENCY = 4 + 31 + STEPS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [qsa_pkg::OUT_W-1:0] rsp_tdata;

   typedef struct packed {
      logic [15:0] roll;
      logic signed [15:0] decl;
      logic [15:0] ra;
   } angles_type;

   angles_type angles_q[$];
   int  errors = 0;
   int  stall_left = 0;
   bit  idle_on = 1'b1;

   quaternion_to_spherical_angles dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_angle(longint x, longint y);
      longint z, dx, dy, t;
      z = 0;
      for (int n = 0; n < STEPS; n++) begin
         dx = floor_shift(y, n);
         dy = floor_shift(x, n);
         t = (n > 31) ? 0 : longint'(qsa_pkg::ATAN_TABLE[n]);
         if (y >= 0) begin
            x += dx; y -= dy; z += t;
         end else begin
            x -= dx; y += dy; z -= t;
         end
      end
      return z;
   endfunction

   function automatic logic [31:0] turn_of(longint y, longint x);
      logic [31:0] base;
      base = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x; y = -y; base = 32'h8000_0000;
      end
      return base + 32'(cordic_angle(x, y));
   endfunction

   function automatic longint unsigned root_of(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] round_turn(logic [31:0] a);
      logic [32:0] s;
      s = {1'b0, a} + 33'h8000;
      return s[31:16];
   endfunction

   function automatic angles_type attitude_angles(logic [63:0] q);
      longint r, i, j, k, ray, rax, s, rly, rlx, d;
      longint unsigned c;
      angles_type a;
      r = longint'($signed(q[15:0]));
      i = longint'($signed(q[31:16]));
      j = longint'($signed(q[47:32]));
      k = longint'($signed(q[63:48]));
      ray = 2 * (i * j - r * k);
      rax = (64'sd1 <<< 30) - 2 * (j * j + k * k);
      s = 2 * (-(r * j) - i * k);
      rly = 2 * (j * k - r * i);
      rlx = (64'sd1 <<< 30) - 2 * (i * i + j * j);
      a.ra = round_turn(turn_of(ray, rax));
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
      c = root_of((64'd1 << 60) - longint'(s * s));
      d = -cordic_angle(longint'(c), s);
      d = (d + 32768) >>> 16;
      if (d > 16384) d = 16384;
      if (d < -16384) d = -16384;
      a.decl = d[15:0];
      a.roll = round_turn(32'd0 - turn_of(rly, rlx));
      return a;
   endfunction

   task automatic send_quaternion(logic [15:0] r, logic [15:0] i,
                                  logic [15:0] j, logic [15:0] k);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {k, j, i, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angles_q.push_back(attitude_angles({k, j, i, r}));
   endtask

   task automatic release_request();
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_component();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_extremes();
      logic [15:0] v [0:3];
      v = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      send_quaternion(0, 0, 0, 0);
      send_quaternion(16'h7FFF, 0, 0, 0);
      send_quaternion(16'h8000, 0, 0, 0);
      send_quaternion(0, 16'h7FFF, 0, 0);
      send_quaternion(0, 0, 16'h7FFF, 0);
      send_quaternion(0, 0, 0, 16'h7FFF);
      send_quaternion(0, 0, 0, 16'h8000);
      send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quaternion(16'h5A82, 0, 16'h5A82, 0);
      send_quaternion(16'h5A82, 0, 16'hA57E, 0);
      send_quaternion(16'h7FFF, 0, 16'h7FFF, 0);
      send_quaternion(16'h7FFF, 0, 16'h8000, 0);
      send_quaternion(0, 0, 0, 16'h0001);
      send_quaternion(16'h4000, 16'h4000, 16'h4000, 16'h4000);
      send_quaternion(16'h0010, 16'h0001, 16'h0002, 16'hFFFF);
      for (int n = 0; n < 8; n++)
         send_quaternion(v[$urandom_range(0, 3)], v[$urandom_range(0, 3)],
                         v[$urandom_range(0, 3)], v[$urandom_range(0, 3)]);
   endtask

   task automatic test_drain_pause();
      release_request();
      while (angles_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++)
         send_quaternion(rand_component(), rand_component(),
                         rand_component(), rand_component());
   endtask

   always @(posedge clock) begin
      if (!idle_on)
         stall_left = 0;
      else if (!reset && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 14);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      angles_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (angles_q.size() == 0) begin
            $display("%0t unexpected response %h", $time, got);
            errors++;
         end else begin
            want = angles_q.pop_front();
            if (got.ra !== want.ra) begin
               $display("%0t right_ascension exp %0d got %0d", $time, want.ra, got.ra);
               errors++;
            end
            if (got.decl !== want.decl) begin
               $display("%0t declination exp %0d got %0d", $time, want.decl, got.decl);
               errors++;
            end
            if (got.roll !== want.roll) begin
               $display("%0t roll_angle exp %0d got %0d", $time, want.roll, got.roll);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_drain_pause();
      test_random(700);
      test_drain_pause();
      idle_on = 1'b0;
      test_random(180);
      release_request();
      while (angles_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && angles_q.size() == 0)
         $display("PASS quaternion_to_spherical_angles");
      else
         $display("FAIL quaternion_to_spherical_angles");
      $finish;
   end

   initial begin
      #400000;
      $display("FAIL quaternion_to_spherical_angles");
      $finish;
   end

endmodule
